>>> src/gsf_pkg.sv
// ----------------------------------------------------------------------------
// gsf_pkg - shared types and constants of the Gaussian smoothing FIR
// Sample and coefficient widths, register indexes, tap bus between the
// window front end and the multiply-accumulate back end.
// ----------------------------------------------------------------------------
package gsf_pkg;

	localparam int SAMPLE_BITS   = 32;
	localparam int MAX_HALF_TAPS = 6;
	localparam int WIN_LEN       = 2 * MAX_HALF_TAPS + 1;
	localparam int IDX_W         = $clog2(WIN_LEN);
	localparam int HALF_W        = 3;
	localparam int COEF_W        = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int FRAC_BITS     = 15;

	// pair sum of two samples, product with an unsigned weight, final sum
	localparam int PAIR_W = SAMPLE_BITS + 1;
	localparam int PROD_W = PAIR_W + COEF_W + 1;
	localparam int ACC_W  = PROD_W + $clog2(MAX_HALF_TAPS + 1);
	localparam int SPLIT  = (MAX_HALF_TAPS + 2) / 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_TAPS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 3'd1;

	localparam logic [COEF_W-1:0] COEF_CENTER_RST = 16'h8000;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [PAIR_W-1:0]      pair_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic [COEF_W-1:0]             coef_t;
	typedef coef_t [MAX_HALF_TAPS:0]       coef_vec_t;

	// index 0 carries the center sample, index d the sum of the pair at distance d
	typedef struct packed {
		logic                     valid;
		logic                     last;
		pair_t [MAX_HALF_TAPS:0]  pair;
	} tap_bus_t;

	localparam acc_t ROUND_BIAS = acc_t'(2 ** (FRAC_BITS - 1));
	localparam acc_t SAT_MAX =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam acc_t SAT_MIN =
		{{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

endpackage

>>> src/gaussian_smoothing_fir_unit.sv
// A result passes register _s1 and the MAC stages _s2, _s3 and _s4 before the output.
// Throughput: one item per cycle unless out_ready back-pressure stalls the MAC pipeline.
// A final_sample item with half_taps H > 0 starts a flush that repeats the last sample H times, input held off.
// Reset clears track state and pipeline valid bits, and returns the registers to
// half_taps 0, center weight 32768, side weights 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
// gaussian_smoothing_fir_unit - symmetric Gaussian FIR smoother, top level
// Holds the configuration registers and connects the window front end to the
// multiply-accumulate back end.
// ----------------------------------------------------------------------------
module gaussian_smoothing_fir_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gsf_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [gsf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  gsf_pkg::sample_t                  sample,
	input  logic                              final_sample,
	input  logic                              in_valid,
	output logic                              in_ready,
	output gsf_pkg::sample_t                  smoothed,
	output logic                              final_result,
	output logic                              out_valid,
	input  logic                              out_ready
);

	logic [gsf_pkg::HALF_W-1:0] half_taps_q;
	gsf_pkg::coef_vec_t         coef_q;
	gsf_pkg::tap_bus_t          tap_s1;
	logic                       take;

	// configuration registers: taps, then center and side weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_taps_q <= '0;
			coef_q      <= {{(gsf_pkg::MAX_HALF_TAPS * gsf_pkg::COEF_W){1'b0}},
				gsf_pkg::COEF_CENTER_RST};
		end else if (cfg_we) begin
			if (cfg_idx == gsf_pkg::CFG_HALF_TAPS) begin
				half_taps_q <= cfg_data[gsf_pkg::HALF_W-1:0];
			end else begin
				coef_q[cfg_idx - gsf_pkg::CFG_COEF_CENTER] <=
					cfg_data[gsf_pkg::COEF_W-1:0];
			end
		end
	end

	gsf_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.half_taps    (half_taps_q),
		.sample       (sample),
		.final_sample (final_sample),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.take         (take),
		.tap_s1       (tap_s1)
	);

	gsf_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.tap_s1       (tap_s1),
		.coef         (coef_q),
		.take         (take),
		.smoothed     (smoothed),
		.final_result (final_result),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule

>>> src/gsf_window.sv
// ----------------------------------------------------------------------------
// gsf_window - sample window and track control
// Holds the sample window, fills it with the first sample of a track, counts
// the fill, runs the end-of-track flush and registers the folded taps (_s1).
// ----------------------------------------------------------------------------
module gsf_window (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [gsf_pkg::HALF_W-1:0]         half_taps,
	input  gsf_pkg::sample_t                   sample,
	input  logic                               final_sample,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               take,
	output gsf_pkg::tap_bus_t                  tap_s1
);

	gsf_pkg::sample_t win_q [gsf_pkg::WIN_LEN];
	gsf_pkg::sample_t win_next [gsf_pkg::WIN_LEN];
	gsf_pkg::sample_t last_x_q;
	gsf_pkg::sample_t push_x;

	logic [gsf_pkg::HALF_W-1:0] fill_q, left_q, skip_q;
	logic [gsf_pkg::HALF_W-1:0] h_eff, fill_eff, pending;
	logic [gsf_pkg::IDX_W-1:0]  h_idx;
	logic started_q, flush_q;
	logic en1, accept, step, emit_main, emit_now, last_now;

	logic vld_s1, last_s1;
	gsf_pkg::pair_t [gsf_pkg::MAX_HALF_TAPS:0] pair_s1;
	gsf_pkg::pair_t [gsf_pkg::MAX_HALF_TAPS:0] pair_next;

	// clamp taps to the window size
	assign h_eff = (half_taps > gsf_pkg::HALF_W'(gsf_pkg::MAX_HALF_TAPS)) ?
		gsf_pkg::HALF_W'(gsf_pkg::MAX_HALF_TAPS) : half_taps;
	assign h_idx = gsf_pkg::IDX_W'(h_eff);

	// handshake and step control
	assign en1      = !vld_s1 || take;
	assign in_ready = !flush_q && en1;
	assign accept   = in_valid && in_ready;
	assign step     = accept || (flush_q && en1);
	assign push_x   = flush_q ? last_x_q : sample;

	// fill count as seen by this item, clamped to the current taps
	assign fill_eff  = !started_q ? '0 : ((fill_q > h_eff) ? h_eff : fill_q);
	assign emit_main = (fill_eff == h_eff);
	assign pending   = emit_main ? h_eff : fill_eff + 1'b1;

	assign emit_now = flush_q ? (skip_q == '0) : emit_main;
	assign last_now = flush_q ? (left_q == gsf_pkg::HALF_W'(1)) :
		(final_sample && (h_eff == '0));

	// next window: replicate the first sample of a track, else shift in
	always_comb begin
		if (!flush_q && !started_q) begin
			for (int i = 0; i < gsf_pkg::WIN_LEN; i++) begin
				win_next[i] = push_x;
			end
		end else begin
			win_next[0] = push_x;
			for (int i = 1; i < gsf_pkg::WIN_LEN; i++) begin
				win_next[i] = win_q[i-1];
			end
		end
	end

	// fold the symmetric taps around the center
	always_comb begin : fold
		logic [gsf_pkg::IDX_W-1:0] lo_idx;
		logic [gsf_pkg::IDX_W-1:0] hi_idx;
		lo_idx = '0;
		hi_idx = '0;
		pair_next[0] = gsf_pkg::pair_t'(win_next[h_idx]);
		for (int d = 1; d <= gsf_pkg::MAX_HALF_TAPS; d++) begin
			if (gsf_pkg::IDX_W'(d) <= h_idx) begin
				lo_idx = h_idx - gsf_pkg::IDX_W'(d);
				hi_idx = h_idx + gsf_pkg::IDX_W'(d);
				pair_next[d] = gsf_pkg::pair_t'(win_next[lo_idx]) +
					gsf_pkg::pair_t'(win_next[hi_idx]);
			end else begin
				pair_next[d] = '0;
			end
		end
	end

	// track control and flush counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			flush_q   <= 1'b0;
			fill_q    <= '0;
			left_q    <= '0;
			skip_q    <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (accept) begin
				if (final_sample) begin
					started_q <= 1'b0;
					fill_q    <= '0;
					if (h_eff != '0) begin
						flush_q <= 1'b1;
						left_q  <= h_eff;
						skip_q  <= h_eff - pending;
					end
				end else begin
					started_q <= 1'b1;
					fill_q    <= emit_main ? fill_eff : fill_eff + 1'b1;
				end
			end else if (flush_q && en1) begin
				left_q <= left_q - 1'b1;
				if (skip_q != '0) begin
					skip_q <= skip_q - 1'b1;
				end
				if (left_q == gsf_pkg::HALF_W'(1)) begin
					flush_q <= 1'b0;
				end
			end
			if (en1) begin
				vld_s1 <= step && emit_now;
			end
		end
	end

	// window and tap payload
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < gsf_pkg::WIN_LEN; i++) begin
				win_q[i] <= win_next[i];
			end
		end
		if (accept) begin
			last_x_q <= sample;
		end
		if (en1 && step) begin
			pair_s1 <= pair_next;
			last_s1 <= last_now;
		end
	end

	always_comb begin
		tap_s1.valid = vld_s1;
		tap_s1.last  = last_s1;
		tap_s1.pair  = pair_s1;
	end

`ifndef NO_ASSERTIONS
	// a flush never overlaps an open track
	a_flush_closed: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !started_q)
		else $error("flush while a track is open");

	// the last flush step always emits, so the track end is marked
	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (skip_q < left_q))
		else $error("flush would end without a final item");

	// fill count stays within the window
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= gsf_pkg::HALF_W'(gsf_pkg::MAX_HALF_TAPS))
		else $error("fill count beyond window");
`endif

endmodule

>>> src/gsf_mac.sv
// ----------------------------------------------------------------------------
// gsf_mac - weight, sum, round and saturate
// Multiplies each folded tap by its weight (_s2), forms two partial sums with
// the rounding bias (_s3), then rounds, saturates and holds the result (_s4).
// ----------------------------------------------------------------------------
module gsf_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gsf_pkg::tap_bus_t     tap_s1,
	input  gsf_pkg::coef_vec_t    coef,
	output logic                  take,
	output gsf_pkg::sample_t      smoothed,
	output logic                  final_result,
	output logic                  out_valid,
	input  logic                  out_ready
);

	logic vld_s2, vld_s3, vld_s4;
	logic last_s2, last_s3, last_s4;
	logic en2, en3, en4;

	gsf_pkg::prod_t prod_s2 [gsf_pkg::MAX_HALF_TAPS+1];
	gsf_pkg::acc_t  sum_a_s3, sum_b_s3;
	gsf_pkg::acc_t  sum_a, sum_b, total, rounded;
	gsf_pkg::sample_t smoothed_s4;

	// stall chain, bubbles collapse
	assign en4  = !vld_s4 || out_ready;
	assign en3  = !vld_s3 || en4;
	assign en2  = !vld_s2 || en3;
	assign take = en2;

	// partial sums, bias folded into the first
	always_comb begin
		sum_a = gsf_pkg::ROUND_BIAS;
		sum_b = '0;
		for (int k = 0; k <= gsf_pkg::MAX_HALF_TAPS; k++) begin
			if (k < gsf_pkg::SPLIT) begin
				sum_a = sum_a + gsf_pkg::acc_t'(prod_s2[k]);
			end else begin
				sum_b = sum_b + gsf_pkg::acc_t'(prod_s2[k]);
			end
		end
	end

	// add the partial sums and drop the fraction; the clamp to the sample range follows in _s4
	assign total   = sum_a_s3 + sum_b_s3;
	assign rounded = total >>> gsf_pkg::FRAC_BITS;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en2) begin
				vld_s2 <= tap_s1.valid;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
			if (en4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en2 && tap_s1.valid) begin
			for (int k = 0; k <= gsf_pkg::MAX_HALF_TAPS; k++) begin
				prod_s2[k] <= $signed(tap_s1.pair[k]) * $signed({1'b0, coef[k]});
			end
			last_s2 <= tap_s1.last;
		end
		if (en3 && vld_s2) begin
			sum_a_s3 <= sum_a;
			sum_b_s3 <= sum_b;
			last_s3  <= last_s2;
		end
		if (en4 && vld_s3) begin
			if (rounded > gsf_pkg::SAT_MAX) begin
				smoothed_s4 <= gsf_pkg::SAT_MAX[gsf_pkg::SAMPLE_BITS-1:0];
			end else if (rounded < gsf_pkg::SAT_MIN) begin
				smoothed_s4 <= gsf_pkg::SAT_MIN[gsf_pkg::SAMPLE_BITS-1:0];
			end else begin
				smoothed_s4 <= rounded[gsf_pkg::SAMPLE_BITS-1:0];
			end
			last_s4 <= last_s3;
		end
	end

	assign smoothed     = smoothed_s4;
	assign final_result = last_s4;
	assign out_valid    = vld_s4;

`ifndef NO_ASSERTIONS
	// a stalled middle stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !en4) |=> (vld_s3 && $stable(sum_a_s3) && $stable(sum_b_s3)))
		else $error("partial sums lost under stall");
`endif

endmodule
